// ----- sv/pcps_pkg.sv -----
// pcps_pkg: shared types, codes and default sizes for the point charge potential block
// depends on nothing; used by every other file of the block
`timescale 1ns / 1ps
package pcps_pkg;

   localparam int DEF_MAX_CHARGES     = 1024;
   localparam int DEF_COORD_BITS      = 10;
   localparam int DEF_RECIP_FRAC_BITS = 16;

   localparam int FIELD_COORD_W = 10;
   localparam int CHARGE_W      = 16;
   localparam int POT_W         = 48;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REPLACED = 2'd1,
      ST_FULL     = 2'd2,
      ST_POTENTIAL = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic [FIELD_COORD_W-1:0]    pos_x;
      logic [FIELD_COORD_W-1:0]    pos_y;
      logic signed [CHARGE_W-1:0]  charge_value;
   } qitem_type;

   typedef struct packed {
      logic      valid;
      qitem_type item;
   } qlink_type;

   typedef struct packed {
      logic [1:0] level;
      logic       full;
   } qstat_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_RD,
      BK_CHK,
      BK_SQ,
      BK_DIST,
      BK_RECIP,
      BK_MUL,
      BK_ACC,
      BK_OUT
   } bk_state_type;

   typedef enum logic [1:0] {
      RS_IDLE,
      RS_DIV,
      RS_SQRT,
      RS_DONE
   } rs_state_type;

endpackage

// ----- sv/pcps_if.sv -----
// pcps_req_if and pcps_rsp_if: valid/ready channels for requests and results
// depends on pcps_pkg
`timescale 1ns / 1ps
interface pcps_req_if;
   import pcps_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [FIELD_COORD_W-1:0]    pos_x;
   logic [FIELD_COORD_W-1:0]    pos_y;
   logic signed [CHARGE_W-1:0]  charge_value;
   modport source (output valid, op, pos_x, pos_y, charge_value, input ready);
   modport sink (input valid, op, pos_x, pos_y, charge_value, output ready);
endinterface

interface pcps_rsp_if;
   import pcps_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [POT_W-1:0]  potential;
   modport source (output valid, status, potential, input ready);
   modport sink (input valid, status, potential, output ready);
endinterface

// ----- sv/pcps_front.sv -----
// pcps_front: accepts requests, classifies the op and queues them for the back end
// depends on pcps_pkg and pcps_req_if
`timescale 1ns / 1ps
module pcps_front (
   input  logic               clock,
   input  logic               reset,
   pcps_req_if.sink           req,
   output pcps_pkg::qlink_type q_out,
   input  logic               q_ready,
   output pcps_pkg::qstat_type q_stat
);
   import pcps_pkg::*;

   qitem_type  slot_ff [QUEUE_DEPTH];
   qitem_type  slot_in [QUEUE_DEPTH];
   logic [1:0] level_ff, level_in;
   logic [1:0] level_m1;
   logic       push, pop;
   qitem_type  incoming;

   assign req.ready = (level_ff != 2'(QUEUE_DEPTH));
   assign push = req.valid && req.ready;
   assign pop  = q_out.valid && q_ready;
   assign level_m1 = level_ff - 2'd1;

   always_comb begin
      incoming.cmd          = req.op ? CMD_QUERY : CMD_INSERT;
      incoming.pos_x        = req.pos_x;
      incoming.pos_y        = req.pos_y;
      incoming.charge_value = req.charge_value;
   end

   always_comb begin
      slot_in  = slot_ff;
      level_in = level_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if (pop) begin
            slot_in[level_m1[0]] = incoming;
         end else begin
            slot_in[level_ff[0]] = incoming;
         end
      end
      level_in = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign q_out.valid  = (level_ff != 2'd0);
   assign q_out.item   = slot_ff[0];
   assign q_stat.level = level_ff;
   assign q_stat.full  = (level_ff == 2'(QUEUE_DEPTH));
endmodule

// ----- sv/pcps_recip.sv -----
// pcps_recip: iterative round(2^F / sqrt(d)), restoring divide then digit-by-digit root
// depends on pcps_pkg
`timescale 1ns / 1ps
module pcps_recip #(
   parameter int COORD_BITS      = pcps_pkg::DEF_COORD_BITS,
   parameter int RECIP_FRAC_BITS = pcps_pkg::DEF_RECIP_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2*COORD_BITS:0]         dist_sq,
   output logic                          done,
   output logic [RECIP_FRAC_BITS-1:0]    recip
);
   import pcps_pkg::*;

   localparam int DW  = 2 * COORD_BITS + 1;
   localparam int F   = RECIP_FRAC_BITS;
   localparam int QW  = 2 * F + 3;
   localparam int K   = F + 2;
   localparam int CW  = $clog2(QW + 1);

   rs_state_type    state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [2*K-1:0]  mv_ff, mv_in;
   logic [K+1:0]    srem_ff, srem_in;
   logic [K-1:0]    root_ff, root_in;
   logic [F-1:0]    r_ff, r_in;

   logic [DW:0]     dsh;
   logic            nbit;
   logic [K+1:0]    ssh, trial;
   logic [K:0]      rnd;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mv_in    = mv_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      r_in     = r_ff;
      nbit     = (cnt_ff == CW'(QW - 1));
      dsh      = {rem_ff, nbit};
      ssh      = {srem_ff[K-1:0], mv_ff[2*K-1 -: 2]};
      trial    = {root_ff, 2'b01};
      rnd      = {1'b0, root_ff} + (K+1)'(1);
      case (state_ff)
         RS_IDLE: begin
            if (start) begin
               d_in     = dist_sq;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = CW'(QW - 1);
               state_in = RS_DIV;
            end
         end
         RS_DIV: begin
            if (dsh >= {1'b0, d_ff}) begin
               rem_in = DW'(dsh - {1'b0, d_ff});
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = dsh[DW-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               mv_in    = (2*K)'({quo_in});
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = CW'(K - 1);
               state_in = RS_SQRT;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         RS_SQRT: begin
            mv_in = {mv_ff[2*K-3:0], 2'b00};
            if (ssh >= trial) begin
               srem_in = ssh - trial;
               root_in = {root_ff[K-2:0], 1'b1};
            end else begin
               srem_in = ssh;
               root_in = {root_ff[K-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = RS_DONE;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         RS_DONE: begin
            if (rnd[K:1] > (K)'({F{1'b1}})) begin
               r_in = {F{1'b1}};
            end else begin
               r_in = rnd[F:1];
            end
            state_in = RS_IDLE;
         end
         default: state_in = RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mv_ff   <= mv_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      r_ff    <= r_in;
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == RS_DONE);
      end
   end

   assign done  = done_ff;
   assign recip = r_ff;
endmodule

// ----- sv/pcps_back.sv -----
// pcps_back: charge table and sequencer for insert search and potential summation
// depends on pcps_pkg, pcps_recip and pcps_rsp_if
`timescale 1ns / 1ps
module pcps_back #(
   parameter int MAX_CHARGES     = pcps_pkg::DEF_MAX_CHARGES,
   parameter int COORD_BITS      = pcps_pkg::DEF_COORD_BITS,
   parameter int RECIP_FRAC_BITS = pcps_pkg::DEF_RECIP_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  pcps_pkg::qlink_type q_in,
   output logic                q_ready,
   pcps_rsp_if.source          rsp
);
   import pcps_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int F     = RECIP_FRAC_BITS;
   localparam int CNT_W = $clog2(MAX_CHARGES + 1);
   localparam int IDX_W = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
   localparam int DW    = 2 * C + 1;
   localparam int ENT_W = 2 * C + CHARGE_W;
   localparam int EW    = (C > FIELD_COORD_W) ? C : FIELD_COORD_W;
   localparam int PW    = CHARGE_W + F + 1;
   localparam int SHL   = (F < 16) ? 16 - F : 0;
   localparam int SHR   = (F > 16) ? F - 16 : 0;
   localparam logic signed [POT_W-1:0] HALF =
      (SHR > 0) ? (48'sd1 <<< (SHR - 1)) : 48'sd0;
   localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
   localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

   logic [ENT_W-1:0] mem [MAX_CHARGES];
   logic [ENT_W-1:0] rd_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;

   bk_state_type             state_ff, state_in;
   qitem_type                cur_ff, cur_in;
   logic [C-1:0]             x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0]         idx_ff, idx_in, count_ff, count_in;
   logic [C-1:0]             adx_ff, adx_in, ady_ff, ady_in;
   logic [2*C-1:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [F-1:0]             r_ff, r_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [POT_W-1:0]  sum_ff, sum_in;
   status_type               status_ff, status_in;

   logic [C-1:0]             e_col, e_row;
   logic signed [CHARGE_W-1:0] e_amt;
   logic [EW-1:0]            ext_x, ext_y;
   logic [DW-1:0]            dist_sq;
   logic                     rc_start, rc_done;
   logic [F-1:0]             rc_recip;
   logic signed [POT_W-1:0]  p48, term;
   logic signed [POT_W:0]    s49;

   pcps_recip #(
      .COORD_BITS      (COORD_BITS),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (rc_start),
      .dist_sq (dist_sq),
      .done    (rc_done),
      .recip   (rc_recip)
   );

   assign e_col = rd_ff[ENT_W-1 -: C];
   assign e_row = rd_ff[CHARGE_W +: C];
   assign e_amt = rd_ff[CHARGE_W-1:0];
   assign ext_x = EW'(q_in.item.pos_x);
   assign ext_y = EW'(q_in.item.pos_y);
   assign dist_sq = DW'(sqx_ff) + DW'(sqy_ff);
   assign p48   = POT_W'(prod_ff);
   assign term  = ((p48 <<< SHL) + HALF) >>> SHR;
   assign s49   = {sum_ff[POT_W-1], sum_ff} + {term[POT_W-1], term};
   assign q_ready = (state_ff == BK_IDLE);

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      adx_in    = adx_ff;
      ady_in    = ady_ff;
      sqx_in    = sqx_ff;
      sqy_in    = sqy_ff;
      r_in      = r_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_data   = {x_ff, y_ff, cur_ff.charge_value};
      rc_start  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_in.valid) begin
               cur_in   = q_in.item;
               x_in     = ext_x[C-1:0];
               y_in     = ext_y[C-1:0];
               idx_in   = '0;
               sum_in   = '0;
               state_in = BK_RD;
            end
         end
         BK_RD: begin
            if (idx_ff == count_ff) begin
               if (cur_ff.cmd == CMD_QUERY) begin
                  status_in = ST_POTENTIAL;
               end else if (count_ff < CNT_W'(MAX_CHARGES)) begin
                  wr_en     = 1'b1;
                  wr_addr   = count_ff[IDX_W-1:0];
                  count_in  = count_ff + CNT_W'(1);
                  status_in = ST_INSERTED;
               end else begin
                  status_in = ST_FULL;
               end
               state_in = BK_OUT;
            end else begin
               state_in = BK_CHK;
            end
         end
         BK_CHK: begin
            if (cur_ff.cmd == CMD_INSERT) begin
               if (e_col == x_ff && e_row == y_ff) begin
                  wr_en     = 1'b1;
                  status_in = ST_REPLACED;
                  state_in  = BK_OUT;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = BK_RD;
               end
            end else begin
               adx_in   = (x_ff >= e_col) ? x_ff - e_col : e_col - x_ff;
               ady_in   = (y_ff >= e_row) ? y_ff - e_row : e_row - y_ff;
               state_in = BK_SQ;
            end
         end
         BK_SQ: begin
            sqx_in   = adx_ff * adx_ff;
            sqy_in   = ady_ff * ady_ff;
            state_in = BK_DIST;
         end
         BK_DIST: begin
            if (dist_sq == '0) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = BK_RD;
            end else begin
               rc_start = 1'b1;
               state_in = BK_RECIP;
            end
         end
         BK_RECIP: begin
            if (rc_done) begin
               r_in     = rc_recip;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = e_amt * $signed({1'b0, r_ff});
            state_in = BK_ACC;
         end
         BK_ACC: begin
            if (s49[POT_W] != s49[POT_W-1]) begin
               sum_in = s49[POT_W] ? POT_MIN : POT_MAX;
            end else begin
               sum_in = s49[POT_W-1:0];
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = BK_RD;
         end
         BK_OUT: begin
            if (rsp.ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      idx_ff    <= idx_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      r_ff      <= r_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign rsp.valid     = (state_ff == BK_OUT);
   assign rsp.status    = status_ff;
   assign rsp.potential = (status_ff == ST_POTENTIAL) ? sum_ff : '0;
endmodule

// ----- sv/point_charge_potential_sum.sv -----
// point_charge_potential_sum: top level, request queue in front of the charge table engine
// depends on pcps_pkg, pcps_if, pcps_front and pcps_back
`timescale 1ns / 1ps
// Keeps up to MAX_CHARGES point charges and sums charge over distance at a queried
// grid cell. A two-entry request queue accepts requests while the engine works. An
// insert scans the stored charges, reading and comparing each one in turn. A query
// is paced by the shared reciprocal square root unit, which spends one cycle per
// quotient bit of its divide and one per root bit; charges at the queried cell skip
// that unit and add nothing. There is no clearing pass after reset: only entries
// below the stored count are ever used.
module point_charge_potential_sum #(
   parameter int MAX_CHARGES     = pcps_pkg::DEF_MAX_CHARGES,
   parameter int COORD_BITS      = pcps_pkg::DEF_COORD_BITS,
   parameter int RECIP_FRAC_BITS = pcps_pkg::DEF_RECIP_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   pcps_req_if.sink   req,
   pcps_rsp_if.source rsp
);
   import pcps_pkg::*;

   qlink_type q_link;
   logic      q_ready;
   qstat_type q_stat;

   pcps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_out   (q_link),
      .q_ready (q_ready),
      .q_stat  (q_stat)
   );

   pcps_back #(
      .MAX_CHARGES     (MAX_CHARGES),
      .COORD_BITS      (COORD_BITS),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_in    (q_link),
      .q_ready (q_ready),
      .rsp     (rsp)
   );

   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_POTENTIAL |-> rsp.potential == '0)
      else $error("insert result carries a nonzero potential");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req.ready)
      else $error("request queue accepts while full");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= 2'(QUEUE_DEPTH))
      else $error("request queue level out of range");

   a_empty_no_valid: assert property (@(posedge clock) disable iff (reset)
      q_stat.level == 2'd0 |-> !q_link.valid)
      else $error("queue offers a request while empty");
endmodule
